@@ src/ssa_pkg.sv @@
// ----------------------------------------------------------------------------
// ssa_pkg: shared types and constants
// Payload structs, cell transaction struct and fixed-point constants.
// ----------------------------------------------------------------------------
package ssa_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 24;
  localparam int OUT_W     = 17;
  localparam int MAG_W     = IN_W + 1;          // magnitude of a 24-bit difference
  localparam int NUM_W     = IN_W + 2;          // signed difference
  localparam int T_W       = FRAC_BITS + 1;     // position in [0, ONE]
  localparam int F_W       = FRAC_BITS + 3;     // 3*ONE - 2*t
  localparam int U_W       = FRAC_BITS + 5;     // smootherstep inner term
  localparam int PROD_W    = 2 * FRAC_BITS + 6;
  localparam int DIV_CELLS = FRAC_BITS;         // one quotient bit per cell

  localparam logic [T_W-1:0]    ONE    = T_W'(1) << FRAC_BITS;
  localparam logic [PROD_W-1:0] HALF_P = PROD_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [1:0] {
    OP_SMOOTH   = 2'd0,
    OP_SMOOTHER = 2'd1,
    OP_ATTEN    = 2'd2,
    OP_UNDEF    = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    MODE_SMOOTH,
    MODE_SMOOTHER,
    MODE_ONE,
    MODE_NONE
  } mode_e;

  typedef struct packed {
    logic [1:0]             opcode;
    logic signed [IN_W-1:0] value;
    logic signed [IN_W-1:0] bound_a;
    logic signed [IN_W-1:0] bound_b;
  } ssa_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] result;
    logic             zero_range;
  } ssa_out_t;

  typedef struct packed {
    logic                 valid;
    mode_e                mode;
    logic                 zero;
    logic                 forced;
    logic [T_W-1:0]       tf;
    logic [MAG_W-1:0]     rem;
    logic [MAG_W-1:0]     den;
    logic [FRAC_BITS-1:0] q;
  } ssa_div_t;

endpackage

@@ src/smoothstep_attenuation_unit.sv @@
// ----------------------------------------------------------------------------
// smoothstep_attenuation_unit: fixed-point smoothstep / attenuation shaper
// Normalizes the value through a chain of division cells, then runs the
// Hermite polynomial pipeline.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// command   in         start && !busy          in_i  (ssa_in_t)
// result    out        valid_o (one cycle)     res_o (ssa_out_t)
//
// One transaction per cycle. A command passes through the division cell chain,
// which resolves the quotient bits, then through the polynomial pipeline.
// busy is always low; every stage advances each cycle.
// Reset clears the division cells and the valid bits of the polynomial
// pipeline. The receiver cannot stall, so nothing ever holds the pipeline.
// ----------------------------------------------------------------------------
module smoothstep_attenuation_unit import ssa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  ssa_in_t  in_i,
  output logic     valid_o,
  output ssa_out_t res_o
);

  ssa_div_t                 chain [0:DIV_CELLS];
  logic signed [NUM_W-1:0]  v, a, b, cv, one_s, num, den;
  logic [MAG_W-1:0]         an, ad;
  logic                     below, above;
  mode_e                    mode;
  logic [T_W-1:0]           t_fin;

  assign busy  = 1'b0;
  assign one_s = NUM_W'(ONE);

  // Input prep: pick numerator and denominator, resolve the special cases.
  always_comb begin
    v     = NUM_W'(in_i.value);
    a     = NUM_W'(in_i.bound_a);
    b     = NUM_W'(in_i.bound_b);
    cv    = v[NUM_W-1] ? '0 : ((v > one_s) ? one_s : v);
    below = cv < a;
    above = cv > b;
    num   = v - a;
    den   = b - a;
    mode  = MODE_NONE;
    case (opcode_e'(in_i.opcode))
      OP_SMOOTH:   mode = MODE_SMOOTH;
      OP_SMOOTHER: mode = MODE_SMOOTHER;
      OP_ATTEN: begin
        if (below) begin
          mode = MODE_SMOOTH;
          num  = cv;
          den  = a;
        end else if (above) begin
          mode = MODE_SMOOTH;
          num  = cv - one_s;
          den  = b - one_s;
        end else begin
          mode = MODE_ONE;
        end
      end
      default:     mode = MODE_NONE;
    endcase
    an = MAG_W'(num[NUM_W-1] ? -num : num);
    ad = MAG_W'(den[NUM_W-1] ? -den : den);

    chain[0]       = '0;
    chain[0].valid = start && !busy;
    chain[0].mode  = mode;
    chain[0].rem   = an;
    chain[0].den   = ad;
    if (mode == MODE_ONE || mode == MODE_NONE) begin
      chain[0].forced = 1'b1;
    end else if (den == '0) begin
      // zero-width range: step substituted and flagged
      chain[0].zero   = 1'b1;
      chain[0].forced = 1'b1;
      chain[0].tf     = num[NUM_W-1] ? '0 : ONE;
    end else if (num == '0 || (num[NUM_W-1] != den[NUM_W-1])) begin
      chain[0].forced = 1'b1;
    end else if (an >= ad) begin
      chain[0].forced = 1'b1;
      chain[0].tf     = ONE;
    end
  end

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
    ssa_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  assign t_fin = chain[DIV_CELLS].forced ? chain[DIV_CELLS].tf
                                         : T_W'(chain[DIV_CELLS].q);

  ssa_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chain[DIV_CELLS].valid),
    .mode_i  (chain[DIV_CELLS].mode),
    .zero_i  (chain[DIV_CELLS].zero),
    .t_i     (t_fin),
    .valid_o (valid_o),
    .res_o   (res_o)
  );

  // unforced positions come from a quotient strictly below ONE
  a_quot_lt_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[DIV_CELLS].valid && !chain[DIV_CELLS].forced |-> t_fin < ONE)
    else $error("quotient out of range");

  a_res_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> res_o.result <= OUT_W'(ONE))
    else $error("result above one");

  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[DIV_CELLS].valid |-> ##3 valid_o)
    else $error("polynomial pipeline dropped a transaction");

  a_zero_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[DIV_CELLS].valid && chain[DIV_CELLS].zero |->
      (chain[DIV_CELLS].mode == MODE_SMOOTH || chain[DIV_CELLS].mode == MODE_SMOOTHER))
    else $error("zero range flagged on a constant result");

endmodule

@@ src/ssa_div_cell.sv @@
// ----------------------------------------------------------------------------
// ssa_div_cell: one restoring division cell
// Produces one quotient bit and hands the partial remainder to the next cell.
// ----------------------------------------------------------------------------
module ssa_div_cell import ssa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ssa_div_t cell_i,
  output ssa_div_t cell_o
);

  ssa_div_t         cell_d, cell_q;
  logic [MAG_W:0]   rem2;
  logic [MAG_W:0]   diff;

  always_comb begin
    rem2   = {cell_i.rem, 1'b0};
    diff   = rem2 - {1'b0, cell_i.den};
    cell_d = cell_i;
    if (!diff[MAG_W]) begin
      cell_d.rem = diff[MAG_W-1:0];
      cell_d.q   = {cell_i.q[FRAC_BITS-2:0], 1'b1};
    end else begin
      cell_d.rem = rem2[MAG_W-1:0];
      cell_d.q   = {cell_i.q[FRAC_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

@@ src/ssa_poly.sv @@
// ----------------------------------------------------------------------------
// ssa_poly: Hermite polynomial pipeline
// Three stages, one multiplier each: t^2, then t2*(3-2t) or t^3, then t3*u (smootherstep).
// ----------------------------------------------------------------------------
module ssa_poly import ssa_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  mode_e          mode_i,
  input  logic           zero_i,
  input  logic [T_W-1:0] t_i,
  output logic           valid_o,
  output ssa_out_t       res_o
);

  logic                 v1_q, v2_q, v3_q;
  mode_e                m1_q, m2_q;
  logic                 z1_q, z2_q;
  logic [T_W-1:0]       t1_q, t2_q;
  logic [PROD_W-1:0]    p2_q;
  logic [U_W-1:0]       u2_q;
  ssa_out_t             res_q;

  logic [PROD_W-1:0]    sq;
  logic [T_W-1:0]       t2_d;
  logic [F_W-1:0]       f;
  logic [PROD_W-1:0]    m;
  logic [PROD_W-1:0]    p2_d;
  logic [U_W-1:0]       pos, negp, u_d;
  logic [PROD_W-1:0]    p3;
  logic [PROD_W-1:0]    r;
  logic [T_W-1:0]       res_d;

  // stage 1: square
  always_comb begin
    sq   = PROD_W'(t_i) * PROD_W'(t_i);
    t2_d = T_W'((sq + HALF_P) >> FRAC_BITS);
  end

  // stage 2: t2*(3-2t) for smoothstep, rounded t^3 and u for smootherstep
  always_comb begin
    f    = (F_W'(ONE) << 1) + F_W'(ONE) - (F_W'(t1_q) << 1);
    m    = PROD_W'(t2_q) * ((m1_q == MODE_SMOOTHER) ? PROD_W'(t1_q) : PROD_W'(f));
    p2_d = (m1_q == MODE_SMOOTHER) ? ((m + HALF_P) >> FRAC_BITS) : m;
    pos  = U_W'(t2_q) * U_W'(6) + U_W'(ONE) * U_W'(10);
    negp = U_W'(t1_q) * U_W'(15);
    u_d  = (pos > negp) ? pos - negp : '0;
  end

  // stage 3: final product, round, saturate; constant result for MODE_ONE and MODE_NONE
  always_comb begin
    p3 = PROD_W'(p2_q[T_W-1:0]) * PROD_W'(u2_q);
    r  = (((m2_q == MODE_SMOOTHER) ? p3 : p2_q) + HALF_P) >> FRAC_BITS;
    case (m2_q)
      MODE_ONE:  res_d = ONE;
      MODE_NONE: res_d = '0;
      default:   res_d = (r > PROD_W'(ONE)) ? ONE : T_W'(r);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m1_q             <= mode_i;
    z1_q             <= zero_i;
    t1_q             <= t_i;
    t2_q             <= t2_d;
    m2_q             <= m1_q;
    z2_q             <= z1_q;
    p2_q             <= p2_d;
    u2_q             <= u_d;
    res_q.result     <= OUT_W'(res_d);
    res_q.zero_range <= z2_q;
  end

  assign valid_o = v3_q;
  assign res_o   = res_q;

endmodule

@@ dv/ssa_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_checker: result predictor and scoreboard
// Watches the command and result channels, computes the expected weight of
// each accepted command and compares it with the unit's output in order.
// ----------------------------------------------------------------------------
module ssa_checker import ssa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     busy_i,
  input  ssa_in_t  cmd_i,
  input  logic     valid_i,
  input  ssa_out_t res_i,
  output int       fail_count_o,
  output int       pending_o,
  output int       checked_o
);

  localparam longint UNIT = 64'd1 << FRAC_BITS;

  ssa_out_t weight_q[$];

  function automatic longint narrow(longint p);
    return (p + UNIT / 2) >>> FRAC_BITS;
  endfunction

  // clamped num/den position; flags a zero-width range
  function automatic longint position(longint num, longint den, ref bit zr);
    longint an, ad;
    if (den == 0) begin
      zr = 1'b1;
      return (num >= 0) ? UNIT : 0;
    end
    if (num == 0 || ((num < 0) != (den < 0))) return 0;
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    if (an >= ad) return UNIT;
    return (an << FRAC_BITS) / ad;
  endfunction

  function automatic longint hermite3(longint t);
    longint t2, r;
    t2 = narrow(t * t);
    r  = narrow(t2 * (3 * UNIT - 2 * t));
    return (r > UNIT) ? UNIT : r;
  endfunction

  function automatic longint hermite5(longint t);
    longint t2, t3, pos, neg, u, r;
    t2  = narrow(t * t);
    t3  = narrow(t2 * t);
    pos = 6 * t2 + 10 * UNIT;
    neg = 15 * t;
    u   = (pos > neg) ? pos - neg : 0;
    r   = narrow(t3 * u);
    return (r > UNIT) ? UNIT : r;
  endfunction

  function automatic ssa_out_t predict_weight(ssa_in_t c);
    longint v, a, b, cv, r;
    bit zr;
    ssa_out_t o;
    v = c.value; a = c.bound_a; b = c.bound_b;
    zr = 1'b0; r = 0;
    case (opcode_e'(c.opcode))
      OP_SMOOTH:   r = hermite3(position(v - a, b - a, zr));
      OP_SMOOTHER: r = hermite5(position(v - a, b - a, zr));
      OP_ATTEN: begin
        cv = (v < 0) ? 0 : ((v > UNIT) ? UNIT : v);
        if (cv < a) r = hermite3(position(cv, a, zr));
        else if (cv > b) r = hermite3(position(cv - UNIT, b - UNIT, zr));
        else r = UNIT;
      end
      default: r = 0;
    endcase
    o.result = r[OUT_W-1:0];
    o.zero_range = zr;
    return o;
  endfunction

  assign pending_o = weight_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    ssa_out_t exp_w;
    if (!rst_ni) begin
      fail_count_o <= 0;
      checked_o <= 0;
    end else begin
      if (start_i && !busy_i) weight_q.push_back(predict_weight(cmd_i));
      if (valid_i) begin
        if (weight_q.size() == 0) begin
          if (fail_count_o < 10) $display("ERROR: unexpected result %p", res_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_w = weight_q.pop_front();
          checked_o <= checked_o + 1;
          if (exp_w.result !== res_i.result || exp_w.zero_range !== res_i.zero_range)
          begin
            if (fail_count_o < 10)
              $display("ERROR: result exp %0d/%0b got %0d/%0b", exp_w.result,
                       exp_w.zero_range, res_i.result, res_i.zero_range);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: smoothstep attenuation unit testbench
// Directed corner commands, then random commands in idle phases; the
// checker predicts each weight and compares it with the unit's output.
// ----------------------------------------------------------------------------
module tb import ssa_pkg::*;;

  localparam int LATENCY   = FRAC_BITS + 3;
  localparam int CYCLE_CAP = 400000;
  localparam int N_RANDOM  = 1600;

  logic     clk_i, rst_ni, start, busy, valid_o;
  ssa_in_t  in_i;
  ssa_out_t res_o;
  int       fail_count, pending, checked, cycles, idle_pct, phase;

  smoothstep_attenuation_unit u_top (
    .clk_i, .rst_ni, .start, .busy, .in_i, .valid_o, .res_o
  );

  ssa_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .cmd_i(in_i),
    .valid_i(valid_o), .res_i(res_o), .fail_count_o(fail_count),
    .pending_o(pending), .checked_o(checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // timeout watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // one transaction; random idle gap before it per the current phase
  task automatic send(logic [1:0] op, logic [23:0] v, logic [23:0] a, logic [23:0] b);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    in_i  <= '{opcode: op, value: v, bound_a: a, bound_b: b};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Q.16 value near the unit interval most of the time, else full range or exactly 0 or one
  function automatic logic [23:0] pick_val();
    int sel;
    sel = $urandom_range(9);
    if (sel < 6) return 24'($signed($urandom_range(163840)) - 32768);
    if (sel < 8) return 24'($urandom);
    return 24'($urandom_range(3) == 0 ? 0 : 65536);
  endfunction

  initial begin
    logic [23:0] a, v;
    cycles = 0;
    idle_pct = 0;
    start = 1'b0;
    in_i = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every opcode, zero range, reversed bounds, undefined op
    send(OP_SMOOTH,   24'h000000, 24'h000000, 24'h010000);
    send(OP_SMOOTH,   24'h008000, 24'h000000, 24'h010000);
    send(OP_SMOOTH,   24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    send(OP_SMOOTH,   24'h800000, 24'h7FFFFF, 24'h800000);
    send(OP_SMOOTH,   24'h000100, 24'h000100, 24'h000100);   // zero range, at
    send(OP_SMOOTH,   24'h0000FF, 24'h000100, 24'h000100);   // zero range, below
    send(OP_SMOOTH,   24'h004000, 24'h010000, 24'h000000);   // reversed
    send(OP_SMOOTHER, 24'h004000, 24'h000000, 24'h010000);
    send(OP_SMOOTHER, 24'hFFFFFF, 24'h000000, 24'h010000);
    send(OP_SMOOTHER, 24'h7FFFFF, 24'h000000, 24'h000001);
    send(OP_SMOOTHER, 24'h123456, 24'h123456, 24'h123456);
    send(OP_SMOOTHER, 24'h00C000, 24'h010000, 24'h000000);
    send(OP_ATTEN,    24'h002000, 24'h004000, 24'h00C000);   // rising
    send(OP_ATTEN,    24'h008000, 24'h004000, 24'h00C000);   // flat
    send(OP_ATTEN,    24'h00E000, 24'h004000, 24'h00C000);   // falling
    send(OP_ATTEN,    24'h800000, 24'h000000, 24'h010000);
    send(OP_ATTEN,    24'h7FFFFF, 24'h000000, 24'h00FFFF);
    send(OP_ATTEN,    24'h008000, 24'h800000, 24'h7FFFFF);
    send(OP_ATTEN,    24'h000000, 24'h000000, 24'h000000);
    send(OP_UNDEF,    24'h7FFFFF, 24'h800000, 24'hFFFFFF);
    send(OP_UNDEF,    24'h800000, 24'h7FFFFF, 24'h000000);

    // random phases: none, mostly idle, moderate, none again
    for (int i = 0; i < N_RANDOM; i++) begin
      phase = i / (N_RANDOM / 4);
      idle_pct = (phase == 1) ? 77 : (phase == 2) ? 19 : 0;
      a = pick_val();
      v = pick_val();
      if ($urandom_range(4) == 0) a = v;
      send(2'($urandom_range(15) == 0 ? 3 : $urandom_range(2)),
           v, a, ($urandom_range(9) == 0) ? a : pick_val());
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);

    $display("Summary: %0d results checked over directed corners and random",
             checked);
    $display("commands in four idle phases; %0d mismatches", fail_count);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
